### hw/rtl/skt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and codes of the sorted key table: record layout, cell
// commands, operation and status codes.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam int KEY_W    = 31;
    localparam int CODE_W   = 16;
    localparam int SLOT_W   = 6;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 56;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_KEY   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_MATCH     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH  = 3'd6;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [CODE_W-1:0] handle;
        logic [CODE_W-1:0] city;
        logic [CODE_W-1:0] region;
        logic [CODE_W-1:0] nation;
    } skt_rec_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [KEY_W-1:0] key;
        skt_rec_t         new_rec;
    } skt_cmd_t;

    typedef struct packed {
        logic gt;
        logic eq;
    } skt_flag_t;

endpackage

### hw/rtl/skt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_cell
// One slot of the sorted key table. Holds a record, compares its key with
// the request key and loads from itself, its neighbors or the new record.
// ----------------------------------------------------------------------------
module skt_cell
(
    input  logic              clk,
    input  logic              rst_n,
    input  skt_pkg::skt_cmd_t cmd,
    input  logic              prev_gt,
    input  skt_pkg::skt_rec_t left_rec,
    input  skt_pkg::skt_rec_t right_rec,
    output skt_pkg::skt_rec_t rec,
    output skt_pkg::skt_flag_t flag
);

    skt_pkg::skt_rec_t rec_reg;
    skt_pkg::skt_rec_t rec_next;

    // An empty slot counts as larger than any key, so the insert point is
    // the first slot that reports gt.
    always_comb
    begin
        flag.gt = (rec_reg.key == '0) || (rec_reg.key > cmd.key);
        flag.eq = (rec_reg.key != '0) && (rec_reg.key == cmd.key);
    end

    always_comb
    begin
        rec_next = rec_reg;
        case (cmd.op)
            skt_pkg::CELL_INSERT:
            begin
                if (prev_gt)
                begin
                    rec_next = left_rec;
                end
                else if (flag.gt)
                begin
                    rec_next = cmd.new_rec;
                end
            end
            skt_pkg::CELL_DELETE:
            begin
                if (flag.gt || flag.eq)
                begin
                    rec_next = right_rec;
                end
            end
            skt_pkg::CELL_ROTATE:
            begin
                rec_next = right_rec;
            end
            default:
            begin
                rec_next = rec_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg <= '0;
        end
        else
        begin
            rec_reg <= rec_next;
        end
    end

    assign rec = rec_reg;

endmodule

### hw/rtl/sorted_key_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_unit
// Table of records kept sorted by a nonzero key, built as a row of cells.
// ----------------------------------------------------------------------------
// The table is a row of TABLE_ENTRIES cells and is empty after reset. A
// request is taken only while the unit is idle. Insert and delete first
// capture the request; then, once the output register is free, every cell
// compares its key and moves its record in a single step. A search rotates
// the whole table through cell 0, one slot per cycle while the result side
// does not stall; matches come out in slot order. Each result waits in an
// output register, so the next request can be taken while it is still
// held.
module sorted_key_table_unit
#(
    parameter int TABLE_ENTRIES = skt_pkg::TABLE_ENTRIES_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // roll_key, record_handle, city_code, region_code, nation_code,
    // query_code, zero pad (lowest bit first)
    input  logic [skt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // operation
    input  logic [skt_pkg::OP_W-1:0]         s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // slot_index, found_key, found_handle, zero pad (lowest bit first)
    output logic [skt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // status
    output logic [skt_pkg::STATUS_W-1:0]     m_axis_tuser,
    output logic                             m_axis_tlast
);

    localparam int KEY_W  = skt_pkg::KEY_W;
    localparam int CODE_W = skt_pkg::CODE_W;
    localparam int SLOT_W = skt_pkg::SLOT_W;
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int PAD_W  = skt_pkg::OUT_DATA_W - SLOT_W - KEY_W - CODE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } state_t;

    state_t state_reg, state_next;

    logic [skt_pkg::OP_W-1:0] op_reg, op_next;
    logic [KEY_W-1:0]         key_reg, key_next;
    logic [CODE_W-1:0]        handle_reg, handle_next;
    logic [CODE_W-1:0]        city_reg, city_next;
    logic [CODE_W-1:0]        region_reg, region_next;
    logic [CODE_W-1:0]        nation_reg, nation_next;
    logic [CODE_W-1:0]        query_reg, query_next;

    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0]        pend_slot_reg, pend_slot_next;
    logic [KEY_W-1:0]         pend_key_reg, pend_key_next;
    logic [CODE_W-1:0]        pend_handle_reg, pend_handle_next;

    logic                     out_valid_reg, out_valid_next;
    logic [skt_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [SLOT_W-1:0]        out_slot_reg, out_slot_next;
    logic [KEY_W-1:0]         out_key_reg, out_key_next;
    logic [CODE_W-1:0]        out_handle_reg, out_handle_next;
    logic                     out_last_reg, out_last_next;

    skt_pkg::skt_cmd_t        cmd;
    skt_pkg::skt_rec_t        cell_rec  [TABLE_ENTRIES];
    skt_pkg::skt_flag_t       cell_flag [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] gt_vec;
    logic [TABLE_ENTRIES-1:0] eq_vec;
    logic [TABLE_ENTRIES-1:0] ins_hot;
    logic [TABLE_ENTRIES-1:0] del_hot;
    logic [SLOT_W-1:0]        ins_slot;
    logic [SLOT_W-1:0]        del_slot;
    logic [CODE_W-1:0]        del_handle;
    logic                     found;
    logic                     full;
    logic                     head_match;
    logic                     out_free;
    logic                     rotating;

    // ---------------------------------------------------------------- cells
    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++)
        begin : g_cell
            skt_pkg::skt_rec_t left_rec;
            skt_pkg::skt_rec_t right_rec;
            logic              prev_gt;

            if (g == 0)
            begin : g_first
                assign left_rec = '0;
                assign prev_gt  = 1'b0;
            end
            else
            begin : g_mid_left
                assign left_rec = cell_rec[g-1];
                assign prev_gt  = gt_vec[g-1];
            end

            // The last cell refills with an empty record on delete and
            // takes cell 0 while the table rotates for a search.
            if (g == TABLE_ENTRIES - 1)
            begin : g_last
                assign right_rec = rotating ? cell_rec[0] : '0;
            end
            else
            begin : g_mid_right
                assign right_rec = cell_rec[g+1];
            end

            skt_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .prev_gt   (prev_gt),
                .left_rec  (left_rec),
                .right_rec (right_rec),
                .rec       (cell_rec[g]),
                .flag      (cell_flag[g])
            );

            assign gt_vec[g] = cell_flag[g].gt;
            assign eq_vec[g] = cell_flag[g].eq;
        end
    endgenerate

    // ------------------------------------------------------ decode of flags
    // Keys are sorted, so gt is a thermometer and equal keys sit together;
    // the first set bit of each marks the slot of interest.
    always_comb
    begin
        ins_hot    = gt_vec & ~{gt_vec[TABLE_ENTRIES-2:0], 1'b0};
        del_hot    = eq_vec & ~{eq_vec[TABLE_ENTRIES-2:0], 1'b0};
        ins_slot   = '0;
        del_slot   = '0;
        del_handle = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (ins_hot[i])
            begin
                ins_slot = ins_slot | SLOT_W'(i);
            end
            if (del_hot[i])
            begin
                del_slot   = del_slot | SLOT_W'(i);
                del_handle = del_handle | cell_rec[i].handle;
            end
        end
        found = |eq_vec;
        full  = (cell_rec[TABLE_ENTRIES-1].key != '0);
        head_match = (cell_rec[0].key != '0) &&
                     ((cell_rec[0].city == query_reg) ||
                      (cell_rec[0].region == query_reg) ||
                      (cell_rec[0].nation == query_reg));
    end

    assign out_free = !out_valid_reg || m_axis_tready;
    assign rotating = (state_reg == S_SCAN) && out_free &&
                      (cnt_reg != CNT_W'(TABLE_ENTRIES));

    always_comb
    begin
        cmd.op      = skt_pkg::CELL_HOLD;
        cmd.key     = key_reg;
        cmd.new_rec = '{key: key_reg, handle: handle_reg, city: city_reg,
                        region: region_reg, nation: nation_reg};
        if (state_reg == S_EXEC && out_free)
        begin
            if (op_reg == skt_pkg::OP_INSERT && !full && key_reg != '0)
            begin
                cmd.op = skt_pkg::CELL_INSERT;
            end
            else if (op_reg == skt_pkg::OP_DELETE && found)
            begin
                cmd.op = skt_pkg::CELL_DELETE;
            end
        end
        else if (rotating)
        begin
            cmd.op = skt_pkg::CELL_ROTATE;
        end
    end

    // -------------------------------------------------------- control logic
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        key_next         = key_reg;
        handle_next      = handle_reg;
        city_next        = city_reg;
        region_next      = region_reg;
        nation_next      = nation_reg;
        query_next       = query_reg;
        cnt_next         = cnt_reg;
        pend_valid_next  = pend_valid_reg;
        pend_slot_next   = pend_slot_reg;
        pend_key_next    = pend_key_reg;
        pend_handle_next = pend_handle_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_status_next  = out_status_reg;
        out_slot_next    = out_slot_reg;
        out_key_next     = out_key_reg;
        out_handle_next  = out_handle_reg;
        out_last_next    = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next     = s_axis_tuser;
                    key_next    = s_axis_tdata[30:0];
                    handle_next = s_axis_tdata[46:31];
                    city_next   = s_axis_tdata[62:47];
                    region_next = s_axis_tdata[78:63];
                    nation_next = s_axis_tdata[94:79];
                    query_next  = s_axis_tdata[110:95];
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (op_reg)
                    skt_pkg::OP_INSERT:
                    begin
                        if (out_free)
                        begin
                            out_valid_next  = 1'b1;
                            out_last_next   = 1'b1;
                            out_slot_next   = '0;
                            out_key_next    = '0;
                            out_handle_next = '0;
                            if (full)
                            begin
                                out_status_next = skt_pkg::ST_FULL;
                            end
                            else if (key_reg == '0)
                            begin
                                out_status_next = skt_pkg::ST_BAD_KEY;
                            end
                            else
                            begin
                                out_status_next = skt_pkg::ST_INSERTED;
                                out_slot_next   = ins_slot;
                                out_key_next    = key_reg;
                                out_handle_next = handle_reg;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    skt_pkg::OP_DELETE:
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            out_last_next  = 1'b1;
                            if (found)
                            begin
                                out_status_next = skt_pkg::ST_DELETED;
                                out_slot_next   = del_slot;
                                out_key_next    = key_reg;
                                out_handle_next = del_handle;
                            end
                            else
                            begin
                                out_status_next = skt_pkg::ST_NOT_FOUND;
                                out_slot_next   = '0;
                                out_key_next    = '0;
                                out_handle_next = '0;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    skt_pkg::OP_SEARCH:
                    begin
                        cnt_next        = '0;
                        pend_valid_next = 1'b0;
                        state_next      = S_SCAN;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SCAN:
            begin
                // A match is held back one step so that the last one can
                // be flagged once the whole table has gone by.
                if (out_free)
                begin
                    if (cnt_reg == CNT_W'(TABLE_ENTRIES))
                    begin
                        out_valid_next = 1'b1;
                        out_last_next  = 1'b1;
                        if (pend_valid_reg)
                        begin
                            out_status_next = skt_pkg::ST_MATCH;
                            out_slot_next   = pend_slot_reg;
                            out_key_next    = pend_key_reg;
                            out_handle_next = pend_handle_reg;
                        end
                        else
                        begin
                            out_status_next = skt_pkg::ST_NO_MATCH;
                            out_slot_next   = '0;
                            out_key_next    = '0;
                            out_handle_next = '0;
                        end
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        if (head_match)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_next  = 1'b1;
                                out_last_next   = 1'b0;
                                out_status_next = skt_pkg::ST_MATCH;
                                out_slot_next   = pend_slot_reg;
                                out_key_next    = pend_key_reg;
                                out_handle_next = pend_handle_reg;
                            end
                            pend_valid_next  = 1'b1;
                            pend_slot_next   = SLOT_W'(cnt_reg);
                            pend_key_next    = cell_rec[0].key;
                            pend_handle_next = cell_rec[0].handle;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= '0;
            key_reg         <= '0;
            handle_reg      <= '0;
            city_reg        <= '0;
            region_reg      <= '0;
            nation_reg      <= '0;
            query_reg       <= '0;
            cnt_reg         <= '0;
            pend_valid_reg  <= 1'b0;
            pend_slot_reg   <= '0;
            pend_key_reg    <= '0;
            pend_handle_reg <= '0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= '0;
            out_slot_reg    <= '0;
            out_key_reg     <= '0;
            out_handle_reg  <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            key_reg         <= key_next;
            handle_reg      <= handle_next;
            city_reg        <= city_next;
            region_reg      <= region_next;
            nation_reg      <= nation_next;
            query_reg       <= query_next;
            cnt_reg         <= cnt_next;
            pend_valid_reg  <= pend_valid_next;
            pend_slot_reg   <= pend_slot_next;
            pend_key_reg    <= pend_key_next;
            pend_handle_reg <= pend_handle_next;
            out_valid_reg   <= out_valid_next;
            out_status_reg  <= out_status_next;
            out_slot_reg    <= out_slot_next;
            out_key_reg     <= out_key_next;
            out_handle_reg  <= out_handle_next;
            out_last_reg    <= out_last_next;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_handle_reg, out_key_reg, out_slot_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

    // ----------------------------------------------------------- assertions
    // Occupied slots form a prefix of the table except while it rotates.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_SCAN && cell_rec[TABLE_ENTRIES-1].key != '0)
            |-> (cell_rec[0].key != '0))
        else $error("occupied slots do not form a prefix");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && cnt_reg == '0) |-> !pend_valid_reg)
        else $error("stale pending match at start of search");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != skt_pkg::ST_MATCH) |-> out_last_reg)
        else $error("single result not marked last");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == skt_pkg::CELL_INSERT) |=> (cell_rec[0].key != '0))
        else $error("insert left the first slot empty");

endmodule

### verif/skt_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_result_checker
// Watches both stream channels of the sorted key table, keeps a shadow copy
// of the table, works out the results of every accepted request and compares
// each accepted result against the oldest one still owed.
// ----------------------------------------------------------------------------
module skt_result_checker
    import skt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    input  logic                    s_axis_tready,
    input  logic [IN_DATA_W-1:0]    s_axis_tdata,
    input  logic [OP_W-1:0]         s_axis_tuser,
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic [STATUS_W-1:0]     m_axis_tuser,
    input  logic                    m_axis_tlast,
    output int                      mismatch_count,
    output int                      outstanding
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [KEY_W-1:0]    key;
        logic [CODE_W-1:0]   handle;
        logic                last;
    } table_result_t;

    skt_rec_t      shadow_table [TABLE_ENTRIES];
    table_result_t owed_results [$];
    int            fail_tally = 0;
    int            owed_count = 0;

    assign mismatch_count = fail_tally;
    assign outstanding    = owed_count;

    function automatic void queue_result(input logic [STATUS_W-1:0] status,
                                         input int slot,
                                         input logic [KEY_W-1:0] key,
                                         input logic [CODE_W-1:0] handle,
                                         input logic last);
        table_result_t r;
        r.status = status;
        r.slot   = slot[SLOT_W-1:0];
        r.key    = key;
        r.handle = handle;
        r.last   = last;
        owed_results.push_back(r);
    endfunction

    // Empty slots never match, whatever the query code is.
    function automatic bit place_hit(input skt_rec_t rec, input logic [CODE_W-1:0] query);
        return rec.key != '0 &&
               (rec.city == query || rec.region == query || rec.nation == query);
    endfunction

    function automatic void compute_table_results(input logic [OP_W-1:0] op,
                                                  input logic [IN_DATA_W-1:0] data);
        skt_rec_t          fresh;
        logic [CODE_W-1:0] query;
        int                pos;
        int                last_hit;
        fresh.key    = data[KEY_W-1:0];
        fresh.handle = data[KEY_W +: CODE_W];
        fresh.city   = data[KEY_W + CODE_W +: CODE_W];
        fresh.region = data[KEY_W + 2*CODE_W +: CODE_W];
        fresh.nation = data[KEY_W + 3*CODE_W +: CODE_W];
        query        = data[KEY_W + 4*CODE_W +: CODE_W];
        case (op)
            OP_INSERT:
            begin
                if (shadow_table[TABLE_ENTRIES-1].key != '0)
                    queue_result(ST_FULL, 0, '0, '0, 1'b1);
                else if (fresh.key == '0)
                    queue_result(ST_BAD_KEY, 0, '0, '0, 1'b1);
                else
                begin
                    // The new record goes in front of the first larger key,
                    // so equal keys keep their arrival order.
                    pos = TABLE_ENTRIES - 1;
                    for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
                        if (shadow_table[i].key == '0 || shadow_table[i].key > fresh.key)
                            pos = i;
                    for (int i = TABLE_ENTRIES - 1; i > pos; i--)
                        shadow_table[i] = shadow_table[i-1];
                    shadow_table[pos] = fresh;
                    queue_result(ST_INSERTED, pos, fresh.key, fresh.handle, 1'b1);
                end
            end
            OP_DELETE:
            begin
                pos = -1;
                if (fresh.key != '0)
                    for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
                        if (shadow_table[i].key == fresh.key)
                            pos = i;
                if (pos < 0)
                    queue_result(ST_NOT_FOUND, 0, '0, '0, 1'b1);
                else
                begin
                    queue_result(ST_DELETED, pos, shadow_table[pos].key,
                                 shadow_table[pos].handle, 1'b1);
                    for (int i = pos; i < TABLE_ENTRIES - 1; i++)
                        shadow_table[i] = shadow_table[i+1];
                    shadow_table[TABLE_ENTRIES-1] = '0;
                end
            end
            OP_SEARCH:
            begin
                last_hit = -1;
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (place_hit(shadow_table[i], query))
                        last_hit = i;
                if (last_hit < 0)
                    queue_result(ST_NO_MATCH, 0, '0, '0, 1'b1);
                else
                    for (int i = 0; i <= last_hit; i++)
                        if (place_hit(shadow_table[i], query))
                            queue_result(ST_MATCH, i, shadow_table[i].key,
                                         shadow_table[i].handle, i == last_hit);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void check_field(input string label, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", label, want, got);
            fail_tally++;
        end
    endfunction

    function automatic void check_result();
        table_result_t want;
        if (owed_results.size() == 0)
        begin
            $error("result with no request owing it: status %0d, tdata %h",
                   m_axis_tuser, m_axis_tdata);
            fail_tally++;
        end
        else
        begin
            want = owed_results.pop_front();
            check_field("status", want.status, m_axis_tuser);
            check_field("slot_index", want.slot, m_axis_tdata[SLOT_W-1:0]);
            check_field("found_key", want.key, m_axis_tdata[SLOT_W +: KEY_W]);
            check_field("found_handle", want.handle,
                        m_axis_tdata[SLOT_W + KEY_W +: CODE_W]);
            check_field("last", want.last, m_axis_tlast);
        end
    endfunction

    // A result leaving at the same edge as a request arrives always belongs
    // to an earlier request, so results are checked first.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
                shadow_table[i] = '0;
            owed_results.delete();
            owed_count <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (s_axis_tvalid && s_axis_tready)
                compute_table_results(s_axis_tuser, s_axis_tdata);
            owed_count <= owed_results.size();
        end
    end

endmodule

### verif/tb_sorted_key_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_key_table_unit
// Stimulus and verdict for the sorted key table unit. A short directed run
// covers empty, invalid and boundary requests; a random run then fills the
// table past full, drains it and mixes all operations, with random gaps on
// the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_sorted_key_table_unit;

    import skt_pkg::*;

    localparam int TABLE_ENTRIES  = TABLE_ENTRIES_DEF;
    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_ITEMS   = 250;
    localparam int FILL_END       = 110;
    localparam int DRAIN_END      = 180;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 2 * TABLE_ENTRIES + 16;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [OP_W-1:0]       s_axis_tuser = OP_INSERT;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;
    logic                  m_axis_tlast;

    int mismatch_count;
    int outstanding;
    int idle_cycles = 0;
    int rx_hold = 0;
    bit rx_steady = 1'b0;

    // Keys the table should hold right now, used to aim deletes at hits.
    logic [KEY_W-1:0] live_keys [$];

    always #HALF_PERIOD clk = ~clk;

    sorted_key_table_unit #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    skt_result_checker #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // Mostly short pauses, now and then a long one.
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Small keys repeat often, which exercises ordering among equal keys.
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return '0;
        if (r < 6)
            return '1;
        if (r < 20)
            return KEY_W'($urandom());
        return KEY_W'($urandom_range(1, 300));
    endfunction

    // A small pool of place codes makes searches return several matches.
    function automatic logic [CODE_W-1:0] pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return CODE_W'($urandom_range(0, 65535));
        if (r < 15)
            return '1;
        return CODE_W'($urandom_range(0, 7));
    endfunction

    always @(posedge clk)
    begin
        if (rx_hold != 0)
        begin
            m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end
        else if (!rx_steady && $urandom_range(0, 99) < 25)
        begin
            m_axis_tready <= 1'b0;
            rx_hold <= idle_length() - 1;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[sorted_key_table_unit] ERROR");
            $finish;
        end
    end

    // Drives one request and holds it until accepted. With settle set, the
    // request side then stays quiet until every owed result has come back.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                input logic [CODE_W-1:0] handle,
                                input logic [CODE_W-1:0] city,
                                input logic [CODE_W-1:0] region,
                                input logic [CODE_W-1:0] nation,
                                input logic [CODE_W-1:0] query,
                                input bit no_gap, input bit settle);
        int gap;
        int hit;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {1'b0, query, nation, region, city, handle, key};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (op == OP_INSERT && key != '0 && live_keys.size() < TABLE_ENTRIES)
            live_keys.push_back(key);
        else if (op == OP_DELETE && key != '0)
        begin
            hit = -1;
            for (int i = live_keys.size() - 1; i >= 0; i--)
                if (live_keys[i] == key)
                    hit = i;
            if (hit >= 0)
                live_keys.delete(hit);
        end
        gap = (no_gap || $urandom_range(0, 1) == 0) ? 0 : idle_length();
        if (settle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while (outstanding != 0)
                @(posedge clk);
        end
        else if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        int               r;
        int               issued;
        bit               settle;
        bit               full_zero_done;
        issued = 0;
        full_zero_done = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: nothing to match, nothing to delete, and a zero key.
        send_request(OP_SEARCH, '0, '0, '0, '0, '0, 16'h0000, 0, 0);
        send_request(OP_DELETE, '0, '0, '0, '0, '0, '0, 0, 0);
        send_request(OP_DELETE, 31'd5, '0, '0, '0, '0, '0, 0, 0);
        send_request(OP_INSERT, '0, '1, '1, '1, '1, '1, 0, 0);
        // Largest key with all-ones payload, then equal small keys.
        send_request(OP_INSERT, '1, '1, '1, '1, '1, '0, 0, 0);
        send_request(OP_INSERT, 31'd1, '0, '0, '0, '0, '1, 0, 0);
        send_request(OP_INSERT, 31'd1, 16'd1, '0, '0, '0, '0, 0, 0);
        send_request(OP_INSERT, 31'd50, 16'd2, 16'h1234, 16'h2345, 16'h3456, '0, 0, 0);
        send_request(OP_INSERT, 31'd20, 16'd3, 16'h3456, 16'h0009, 16'h0009, '0, 0, 0);
        // Query zero must skip the empty slots whose codes are also zero.
        send_request(OP_SEARCH, '1, '1, '1, '1, '1, 16'h0000, 0, 0);
        send_request(OP_SEARCH, '0, '0, '0, '0, '0, 16'hFFFF, 0, 0);
        send_request(OP_SEARCH, '0, '0, '0, '0, '0, 16'h3456, 0, 0);
        send_request(OP_SEARCH, '0, '0, '0, '0, '0, 16'h2345, 0, 0);
        send_request(OP_SEARCH, '0, '0, '0, '0, '0, 16'h7777, 0, 0);
        send_request(OP_UNUSED, 31'd1, '1, '0, '0, '0, '0, 0, 0);
        send_request(OP_DELETE, 31'd1, '0, '0, '0, '0, '0, 0, 0);
        send_request(OP_DELETE, '1, '0, '0, '0, '0, '0, 0, 0);
        send_request(OP_DELETE, '0, '0, '0, '0, '0, '0, 0, 0);
        send_request(OP_DELETE, 31'd999, '0, '0, '0, '0, '0, 0, 0);
        send_request(OP_INSERT, 31'd3, 16'd4, 16'd5, 16'd6, 16'd7, '1, 0, 0);

        // Random part: fill past full, drain, then a free mix.
        while (issued < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (issued < FILL_END)
                op = r < 85 ? OP_INSERT : r < 90 ? OP_DELETE : r < 99 ? OP_SEARCH : OP_UNUSED;
            else if (issued < DRAIN_END)
                op = r < 15 ? OP_INSERT : r < 85 ? OP_DELETE : r < 99 ? OP_SEARCH : OP_UNUSED;
            else
                op = r < 40 ? OP_INSERT : r < 70 ? OP_DELETE : r < 99 ? OP_SEARCH : OP_UNUSED;

            if (op == OP_DELETE && live_keys.size() > 0 && $urandom_range(0, 3) != 0)
                key = live_keys[$urandom_range(0, live_keys.size() - 1)];
            else
                key = pick_key();
            // A zero key into a full table must report full, not invalid.
            if (op == OP_INSERT && live_keys.size() == TABLE_ENTRIES && !full_zero_done)
            begin
                key = '0;
                full_zero_done = 1'b1;
            end

            settle = op != OP_UNUSED &&
                     (issued == FILL_END - 1 || issued == RANDOM_ITEMS - 1);
            rx_steady <= issued >= 150 && issued < 190;
            send_request(op, key, pick_code(), pick_code(), pick_code(), pick_code(),
                         pick_code(), issued >= 40 && issued < 70, settle);
            if (op != OP_UNUSED)
                issued++;
        end

        // A search has finished rotating the table by the time its last result leaves.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("[sorted_key_table_unit] OK");
        else
            $display("[sorted_key_table_unit] ERROR");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/skt_pkg.sv
hw/rtl/skt_cell.sv
hw/rtl/sorted_key_table_unit.sv
verif/skt_result_checker.sv
verif/tb_sorted_key_table_unit.sv
